[design/tcw_pkg.sv]
// Package for the text console cell writer: screen geometry, field widths,
// opcode and register codes, payload and memory port structs. No dependencies.
package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   // Derived widths
   localparam int MEM_AW = $clog2(CELLS);
   localparam int CUR_W  = $clog2(CELLS + 1);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS + 1);

   // Field widths
   localparam int CELL_W    = 16;
   localparam int OPC_W     = 2;
   localparam int CHAR_W    = 8;
   localparam int COLUMN_W  = 7;
   localparam int ROW_IDX_W = 5;
   localparam int NIB_W     = 4;
   localparam int POS_W     = 11;
   localparam int CSR_IDX_W = 1;

   localparam int FG_SHIFT = 8;
   localparam int BG_SHIFT = 12;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

   localparam logic [CELL_W-1:0] TEXT_ATTRIBUTE_RESET   = 16'h0700;
   localparam logic [CELL_W-1:0] CURSOR_CELL_WORD_RESET = 16'h7000;

   typedef enum logic [OPC_W-1:0] {
      OP_PUT_CURSOR = 2'd0,
      OP_PUT_AT     = 2'd1,
      OP_CLEAR      = 2'd2,
      OP_READ       = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEXT_ATTRIBUTE   = 1'b0,
      CSR_CURSOR_CELL_WORD = 1'b1
   } csr_index_type;

   typedef struct packed {
      opcode_type             opcode;
      logic [CHAR_W-1:0]      char_code;
      logic [COLUMN_W-1:0]    column;
      logic [ROW_IDX_W-1:0]   row_index;
      logic [NIB_W-1:0]       foreground;
      logic [NIB_W-1:0]       background;
   } req_payload_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_data;
      logic [POS_W-1:0]  cursor_position;
      logic              did_scroll;
   } rsp_payload_type;

   // One write port and one read port per cycle
   typedef struct packed {
      logic              wr_en;
      logic [MEM_AW-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
      logic              rd_en;
      logic [MEM_AW-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type result;
   } seq_done_type;

endpackage

[design/tcw_channels.sv]
// Valid/ready channel interfaces for request and response transfers.
// Depends on tcw_pkg for the payload structs.
interface tcw_req_if;
   import tcw_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[design/tcw_screen_ram.sv]
// Screen memory: CELLS x 16 bits, one write and one read port, registered read.
// Depends on tcw_pkg.
module tcw_screen_ram (
   input  logic                        clock,
   input  tcw_pkg::mem_req_type        mem_req,
   output logic [tcw_pkg::CELL_W-1:0]  rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] cells [CELLS];
   logic [CELL_W-1:0] rd_data_ff;

   // Read data holds until the next read
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         cells[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= cells[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tcw_sequencer.sv]
// Command sequencer: cursor state, screen sweeps (wipe, scroll, blank) and
// the memory access schedule for each command. Depends on tcw_pkg.
module tcw_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  tcw_pkg::req_payload_type    req_item,
   output logic                        ready,
   input  logic [tcw_pkg::CELL_W-1:0]  text_attribute,
   input  logic [tcw_pkg::CELL_W-1:0]  cursor_cell_word,
   input  logic                        out_free,
   output tcw_pkg::seq_done_type       done,
   output tcw_pkg::mem_req_type        mem_req,
   input  logic [tcw_pkg::CELL_W-1:0]  rd_data
);
   import tcw_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_WIPE      = 9'b000000010,
      ST_PUT_A     = 9'b000000100,
      ST_PUT_B     = 9'b000001000,
      ST_SCROLL    = 9'b000010000,
      ST_BLANK     = 9'b000100000,
      ST_POKE      = 9'b001000000,
      ST_PEEK      = 9'b010000000,
      ST_PEEK_DATA = 9'b100000000
   } state_type;

   localparam logic [CUR_W-1:0] LAST_ROW_START = CUR_W'(CELLS - COLUMNS);
   localparam logic [CUR_W-1:0] LAST_CELL      = CUR_W'(CELLS - 1);
   localparam logic [CUR_W-1:0] END_POS        = CUR_W'(CELLS);
   localparam logic [CUR_W-1:0] ROW_STEP       = CUR_W'(COLUMNS);
   localparam logic [ROW_W-1:0] PENDING_ROW    = ROW_W'(ROWS);
   localparam logic [ROW_W-1:0] LAST_ROW       = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] LAST_COL       = COL_W'(COLUMNS - 1);

   state_type         state_ff, state_in;
   logic [CUR_W-1:0]  cursor_ff, cursor_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [CUR_W-1:0]  sweep_ff, sweep_in;
   logic              copy_valid_ff, copy_valid_in;
   logic [MEM_AW-1:0] copy_addr_ff, copy_addr_in;
   logic              scrolled_ff, scrolled_in;
   logic              wipe_item_ff, wipe_item_in;
   req_payload_type   item_ff, item_in;

   logic              pending;
   logic              is_newline;
   logic              is_backspace;
   logic              item_inside;
   logic [MEM_AW-1:0] item_pos;
   logic [MEM_AW-1:0] cursor_addr;

   assign pending      = (row_ff == PENDING_ROW);
   assign is_newline   = (item_ff.char_code == CH_NEWLINE);
   assign is_backspace = (item_ff.char_code == CH_BACKSPACE);
   assign item_inside  = (32'(item_ff.column) < COLUMNS) && (32'(item_ff.row_index) < ROWS);
   assign item_pos     = MEM_AW'(32'(item_ff.row_index) * COLUMNS + 32'(item_ff.column));
   assign cursor_addr  = cursor_ff[MEM_AW-1:0];
   assign ready        = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      sweep_in      = sweep_ff;
      copy_valid_in = 1'b0;
      copy_addr_in  = copy_addr_ff;
      scrolled_in   = scrolled_ff;
      wipe_item_in  = wipe_item_ff;
      item_in       = item_ff;

      mem_req       = '0;
      done.valid                  = 1'b0;
      done.result.cell_data       = '0;
      done.result.cursor_position = POS_W'(cursor_ff);
      done.result.did_scroll      = scrolled_ff;

      // Scroll copy: write back the cell read in the previous cycle
      if (copy_valid_ff) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = copy_addr_ff;
         mem_req.wr_data = rd_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in     = req_item;
               scrolled_in = 1'b0;
               case (req_item.opcode)
                  OP_PUT_CURSOR: state_in = ST_PUT_A;
                  OP_PUT_AT:     state_in = ST_POKE;
                  OP_CLEAR: begin
                     sweep_in     = '0;
                     wipe_item_in = 1'b1;
                     cursor_in    = '0;
                     col_in       = '0;
                     row_in       = '0;
                     state_in     = ST_WIPE;
                  end
                  OP_READ:       state_in = ST_PEEK;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end

         ST_WIPE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = sweep_ff[MEM_AW-1:0];
            mem_req.wr_data = '0;
            if (sweep_ff == LAST_CELL) begin
               if (wipe_item_ff) begin
                  done.valid = 1'b1;
                  if (out_free) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         ST_PUT_A: begin
            if (is_newline) begin
               if (!pending) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = cursor_addr;
                  mem_req.wr_data = '0;
               end
               col_in = '0;
               if (row_ff >= LAST_ROW) begin
                  cursor_in   = LAST_ROW_START;
                  row_in      = LAST_ROW;
                  scrolled_in = 1'b1;
                  sweep_in    = ROW_STEP;
                  state_in    = ST_SCROLL;
               end else begin
                  cursor_in = cursor_ff + ROW_STEP - CUR_W'(col_ff);
                  row_in    = row_ff + 1'b1;
                  state_in  = ST_PUT_B;
               end
            end else if (is_backspace) begin
               if (!pending) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = cursor_addr;
                  mem_req.wr_data = '0;
               end
               if (cursor_ff != '0) begin
                  cursor_in = cursor_ff - 1'b1;
                  if (col_ff == '0) begin
                     col_in = LAST_COL;
                     row_in = row_ff - 1'b1;
                  end else begin
                     col_in = col_ff - 1'b1;
                  end
               end
               state_in = ST_PUT_B;
            end else if (pending) begin
               // scroll first, then come back here to place the character
               cursor_in   = LAST_ROW_START;
               row_in      = LAST_ROW;
               col_in      = '0;
               scrolled_in = 1'b1;
               sweep_in    = ROW_STEP;
               state_in    = ST_SCROLL;
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = cursor_addr;
               mem_req.wr_data = text_attribute | CELL_W'(item_ff.char_code);
               cursor_in       = cursor_ff + 1'b1;
               if (col_ff == LAST_COL) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
               state_in = ST_PUT_B;
            end
         end

         ST_PUT_B: begin
            if (!pending) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = cursor_addr;
               mem_req.wr_data = cursor_cell_word;
            end
            done.valid = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         ST_SCROLL: begin
            if (sweep_ff == END_POS) begin
               sweep_in = LAST_ROW_START;
               state_in = ST_BLANK;
            end else begin
               mem_req.rd_en = 1'b1;
               mem_req.rd_addr = sweep_ff[MEM_AW-1:0];
               copy_valid_in = 1'b1;
               copy_addr_in  = MEM_AW'(sweep_ff - ROW_STEP);
               sweep_in      = sweep_ff + 1'b1;
            end
         end

         ST_BLANK: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = sweep_ff[MEM_AW-1:0];
            mem_req.wr_data = '0;
            if (sweep_ff == LAST_CELL) begin
               state_in = is_newline ? ST_PUT_B : ST_PUT_A;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         ST_POKE: begin
            if (item_inside) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = item_pos;
               mem_req.wr_data = (CELL_W'(item_ff.background) << BG_SHIFT)
                               | (CELL_W'(item_ff.foreground) << FG_SHIFT)
                               | CELL_W'(item_ff.char_code);
            end
            done.valid = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         ST_PEEK: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = item_pos;
            state_in        = ST_PEEK_DATA;
         end

         ST_PEEK_DATA: begin
            done.result.cell_data = item_inside ? rd_data : '0;
            done.valid = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_WIPE;
         cursor_ff     <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         sweep_ff      <= '0;
         copy_valid_ff <= 1'b0;
         scrolled_ff   <= 1'b0;
         wipe_item_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         sweep_ff      <= sweep_in;
         copy_valid_ff <= copy_valid_in;
         scrolled_ff   <= scrolled_in;
         wipe_item_ff  <= wipe_item_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      copy_addr_ff <= copy_addr_in;
   end

   // cursor index, row and column must always agree
   a_cursor_coords: assert property (@(posedge clock) disable iff (reset)
      cursor_ff == CUR_W'(32'(row_ff) * COLUMNS + 32'(col_ff)))
      else $error("cursor index out of step with row/column");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (32'(mem_req.wr_addr) < CELLS))
      else $error("memory write beyond the screen");

   // copy write-back only overlaps the scroll read phase
   a_copy_in_scroll: assert property (@(posedge clock) disable iff (reset)
      copy_valid_ff |-> (state_ff == ST_SCROLL))
      else $error("scroll copy write outside scroll phase");

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
      else $error("read and write to the same cell in one cycle");

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (done.valid && !out_free) |=> (state_ff == $past(state_ff)))
      else $error("sequencer left a finishing state with the output full");

endmodule

[design/text_console_cell_writer_unit.sv]
// Top level of the text console cell writer: channels, config registers,
// response register. Depends on tcw_pkg, tcw_channels, tcw_sequencer, tcw_screen_ram.
//
//   port        | dir | kind             | contents
//   ------------+-----+------------------+------------------------------------------
//   req_chan    | in  | valid/ready      | opcode, char_code, column, row_index, fg, bg
//   rsp_chan    | out | valid/ready      | cell_data, cursor_position, did_scroll
//   csr_*       | in  | write-only port  | index 0 text_attribute, 1 cursor_cell_word
//
// Each command runs to completion before the next request is taken.
//   A newline or a character may scroll the screen; a character that scrolls passes the
//   first put state twice. In a scroll the single-port-pair screen RAM moves one cell
//   per cycle (CELLS-COLUMNS copies) and blanks the last row.
// After reset a clearing pass writes zero to every cell; no request is taken during
//   it, csr writes are.
// A finished response sits in rsp_chan's output register; the sequencer holds in its
//   last state while that register is full and not being drained.
module text_console_cell_writer_unit (
   input  logic                          clock,
   input  logic                          reset,
   tcw_req_if.sink                       req_chan,
   tcw_rsp_if.source                     rsp_chan,
   input  logic                          csr_write_enable,
   input  logic [tcw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tcw_pkg::CELL_W-1:0]    csr_write_data
);
   import tcw_pkg::*;

   // Configuration registers
   logic [CELL_W-1:0] text_attr_ff, text_attr_in;
   logic [CELL_W-1:0] cursor_word_ff, cursor_word_in;

   // Response output register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic              seq_ready;
   logic              start;
   logic              out_free;
   seq_done_type      done;
   mem_req_type       mem_req;
   logic [CELL_W-1:0] rd_data;

   assign req_chan.ready = seq_ready;
   assign start          = req_chan.valid && seq_ready;

   // Output register can take a new response when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      text_attr_in   = text_attr_ff;
      cursor_word_in = cursor_word_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_TEXT_ATTRIBUTE:   text_attr_in   = csr_write_data;
            CSR_CURSOR_CELL_WORD: cursor_word_in = csr_write_data;
            default:              text_attr_in   = text_attr_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done.result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff   <= TEXT_ATTRIBUTE_RESET;
         cursor_word_ff <= CURSOR_CELL_WORD_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         text_attr_ff   <= text_attr_in;
         cursor_word_ff <= cursor_word_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   tcw_sequencer u_sequencer (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_item         (req_chan.payload),
      .ready            (seq_ready),
      .text_attribute   (text_attr_ff),
      .cursor_cell_word (cursor_word_ff),
      .out_free         (out_free),
      .done             (done),
      .mem_req          (mem_req),
      .rd_data          (rd_data)
   );

   tcw_screen_ram u_screen_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule
